/* sv/min_heap_deadline_expiry_queue_core_macros.svh */
// Assertion macros shared by the deadline expiry queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MIN_HEAP_DEADLINE_EXPIRY_QUEUE_CORE_MACROS_SVH
`define MIN_HEAP_DEADLINE_EXPIRY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define MHQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define MHQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MHQ_ASSERT(label, clk, rst, prop, msg)
`define MHQ_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

/* sv/mhq_pkg.sv */
// Package for the deadline expiry queue: sizes, beat types, codes and
// controller/datapath interface structs. No dependencies.
`default_nettype none

package mhq_pkg;

   // heap geometry
   localparam int HEAP_DEPTH = 64;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int IDX_W      = ADDR_W + 2;

   localparam int DL_W  = 48;
   localparam int HD_W  = 32;
   localparam int VER_W = 64;
   localparam int ST_W  = 2;

   // request function codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REJECT  = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef struct packed {
      logic             func;
      logic [DL_W-1:0]  deadline;
      logic [DL_W-1:0]  now_time;
      logic [HD_W-1:0]  key_handle;
      logic [VER_W-1:0] entry_version;
      logic [ST_W-1:0]  store_type;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [DL_W-1:0]  out_deadline;
      logic [HD_W-1:0]  out_handle;
      logic [VER_W-1:0] out_version;
      logic [ST_W-1:0]  out_store;
      logic             last;
   } rsp_type;

   // one heap slot
   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [HD_W-1:0]  handle;
      logic [VER_W-1:0] version;
      logic [ST_W-1:0]  store;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SIFT_RD,
      ST_SIFT_CMP
   } state_type;

   // read port address selection
   typedef enum logic [1:0] {
      RD_NONE,
      RD_PARENT,
      RD_ROOT_LAST,
      RD_CHILDREN
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       count_inc;
      rd_sel_type rd_sel;
      logic       wr_x;
      logic       ins_move;
      logic       sift_move;
      logic       pop;
      logic       emit;
      kind_type   emit_kind;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic count_zero;
      logic cur_zero;
      logic x_ge_parent;
      logic root_due;
      logic left_in;
      logic best_is_cur;
      logic pend_vld;
   } stat_type;

endpackage

`default_nettype wire

/* sv/min_heap_deadline_expiry_queue_core.sv */
// Deadline expiry queue: min-heap of timed entries; one insert or tick at a time,
// the next beat is taken in the first cycle busy is low. Insert: result in the
// cycle after acceptance; busy while the entry climbs level by level to its slot,
// not at all when full. Tick: each pop reads root and last entry, sifts down level
// by level and settles, then a final check; each beat comes in the cycle after the
// check that decides it. Sync reset empties the heap; no stalls.
`default_nettype none

module min_heap_deadline_expiry_queue_core
   import mhq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   mhq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat_i   (stat),
      .cmd_o    (cmd),
      .busy     (busy)
   );

   mhq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd_i      (cmd),
      .stat_o     (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* sv/mhq_ctrl.sv */
// Controller for the deadline expiry queue: sequences inserts, pops and
// sift steps. Depends on mhq_pkg.
`default_nettype none

module mhq_ctrl
   import mhq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     req_func,
   input  wire stat_type stat_i,
   output cmd_type       cmd_o,
   output logic          busy
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd_o           = '0;
      cmd_o.rd_sel    = RD_NONE;
      cmd_o.emit_kind = KIND_ACCEPT;
      busy            = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_func == FUNC_INSERT) begin
                  // insert result is known at acceptance
                  cmd_o.emit      = 1'b1;
                  cmd_o.emit_last = 1'b1;
                  cmd_o.emit_kind = stat_i.full ? KIND_REJECT : KIND_ACCEPT;
                  if (!stat_i.full) begin
                     cmd_o.load_req  = 1'b1;
                     cmd_o.count_inc = 1'b1;
                     state_in        = ST_INS_RD;
                  end
               end else begin
                  cmd_o.load_req = 1'b1;
                  state_in       = ST_POP_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (stat_i.cur_zero) begin
               cmd_o.wr_x = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd_o.rd_sel = RD_PARENT;
               state_in     = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (stat_i.x_ge_parent) begin
               cmd_o.wr_x = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd_o.ins_move = 1'b1;
               state_in       = ST_INS_RD;
            end
         end
         ST_POP_RD: begin
            if (stat_i.count_zero) begin
               cmd_o.emit      = 1'b1;
               cmd_o.emit_last = 1'b1;
               cmd_o.emit_kind = stat_i.pend_vld ? KIND_EXPIRED : KIND_NONE;
               state_in        = ST_IDLE;
            end else begin
               cmd_o.rd_sel = RD_ROOT_LAST;
               state_in     = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            cmd_o.emit_kind = KIND_EXPIRED;
            if (!stat_i.root_due) begin
               // tick ends: flush the held entry or report nothing due
               cmd_o.emit      = 1'b1;
               cmd_o.emit_last = 1'b1;
               cmd_o.emit_kind = stat_i.pend_vld ? KIND_EXPIRED : KIND_NONE;
               state_in        = ST_IDLE;
            end else begin
               // another pop follows, so the held entry is not the last
               cmd_o.emit = stat_i.pend_vld;
               cmd_o.pop  = 1'b1;
               state_in   = ST_SIFT_RD;
            end
         end
         ST_SIFT_RD: begin
            if (!stat_i.left_in) begin
               cmd_o.wr_x = 1'b1;
               state_in   = ST_POP_RD;
            end else begin
               cmd_o.rd_sel = RD_CHILDREN;
               state_in     = ST_SIFT_CMP;
            end
         end
         ST_SIFT_CMP: begin
            if (stat_i.best_is_cur) begin
               cmd_o.wr_x = 1'b1;
               state_in   = ST_POP_RD;
            end else begin
               cmd_o.sift_move = 1'b1;
               state_in        = ST_SIFT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/mhq_dpath.sv */
// Datapath for the deadline expiry queue: heap memory, hole register,
// counters, compares and the result register. Depends on mhq_pkg and the macros.
`default_nettype none

`include "min_heap_deadline_expiry_queue_core_macros.svh"

module mhq_dpath
   import mhq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd_i,
   output stat_type     stat_o,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   entry_type         heap_ff [HEAP_DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_vld_ff, pend_vld_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   entry_type         x_ff, x_in;
   entry_type         pend_ff, pend_in;
   logic [DL_W-1:0]   now_ff, now_in;
   entry_type         rd_a_ff, rd_b_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0] par_idx, last_idx, rd_a_addr, rd_b_addr, child_idx;
   logic [IDX_W-1:0]  left_idx, right_idx, count_ext;
   logic              right_in, l_lt, r_lt;
   logic [DL_W-1:0]   best_dl;
   entry_type         child, wr_data, req_entry;
   logic              wr_en;

   // index arithmetic
   assign par_idx   = (cur_ff - ADDR_W'(1)) >> 1;
   assign left_idx  = {1'b0, cur_ff, 1'b1};
   assign right_idx = left_idx + IDX_W'(1);
   assign count_ext = IDX_W'(count_ff);
   assign right_in  = right_idx < count_ext;
   assign last_idx  = ADDR_W'(count_ff - CNT_W'(1));

   // read address decode
   always_comb begin
      unique case (cmd_i.rd_sel)
         RD_PARENT: begin
            rd_a_addr = par_idx;
            rd_b_addr = '0;
         end
         RD_ROOT_LAST: begin
            rd_a_addr = '0;
            rd_b_addr = last_idx;
         end
         RD_CHILDREN: begin
            rd_a_addr = left_idx[ADDR_W-1:0];
            rd_b_addr = right_idx[ADDR_W-1:0];
         end
         default: begin
            rd_a_addr = '0;
            rd_b_addr = '0;
         end
      endcase
   end

   // sift-down pick: smaller child wins, left on ties
   assign l_lt      = stat_o.left_in && (rd_a_ff.deadline < x_ff.deadline);
   assign best_dl   = l_lt ? rd_a_ff.deadline : x_ff.deadline;
   assign r_lt      = right_in && (rd_b_ff.deadline < best_dl);
   assign child     = r_lt ? rd_b_ff : rd_a_ff;
   assign child_idx = r_lt ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

   // status to the controller
   always_comb begin
      stat_o.full        = count_ff == CNT_W'(HEAP_DEPTH);
      stat_o.count_zero  = count_ff == '0;
      stat_o.cur_zero    = cur_ff == '0;
      stat_o.x_ge_parent = x_ff.deadline >= rd_a_ff.deadline;
      stat_o.root_due    = rd_a_ff.deadline <= now_ff;
      stat_o.left_in     = left_idx < count_ext;
      stat_o.best_is_cur = !l_lt && !r_lt;
      stat_o.pend_vld    = pend_vld_ff;
   end

   // heap write port: the hole at cur takes the moving entry or a shifted one
   assign wr_en   = cmd_i.wr_x || cmd_i.ins_move || cmd_i.sift_move;
   assign wr_data = cmd_i.wr_x ? x_ff : (cmd_i.ins_move ? rd_a_ff : child);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[cur_ff] <= wr_data;
      end
      rd_a_ff <= heap_ff[rd_a_addr];
      rd_b_ff <= heap_ff[rd_b_addr];
   end

   assign req_entry = '{deadline: req_data.deadline, handle: req_data.key_handle,
                        version: req_data.entry_version, store: req_data.store_type};

   // next values of the working registers
   always_comb begin
      count_in    = count_ff;
      pend_vld_in = pend_vld_ff;
      cur_in      = cur_ff;
      x_in        = x_ff;
      pend_in     = pend_ff;
      now_in      = now_ff;
      if (cmd_i.load_req) begin
         x_in        = req_entry;
         now_in      = req_data.now_time;
         cur_in      = ADDR_W'(count_ff);
         pend_vld_in = 1'b0;
      end
      if (cmd_i.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd_i.ins_move) begin
         cur_in = par_idx;
      end
      if (cmd_i.sift_move) begin
         cur_in = child_idx;
      end
      if (cmd_i.pop) begin
         // root leaves, last entry becomes the hole's mover
         pend_in     = rd_a_ff;
         pend_vld_in = 1'b1;
         x_in        = rd_b_ff;
         cur_in      = '0;
         count_in    = count_ff - CNT_W'(1);
      end
   end

   // result beat
   always_comb begin
      rsp_strobe_in           = cmd_i.emit;
      rsp_data_in             = '0;
      rsp_data_in.result_kind = cmd_i.emit_kind;
      rsp_data_in.last        = cmd_i.emit_last;
      if (cmd_i.emit_kind == KIND_EXPIRED) begin
         rsp_data_in.out_deadline = pend_ff.deadline;
         rsp_data_in.out_handle   = pend_ff.handle;
         rsp_data_in.out_version  = pend_ff.version;
         rsp_data_in.out_store    = pend_ff.store;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      x_ff    <= x_in;
      pend_ff <= pend_in;
      now_ff  <= now_in;
      if (cmd_i.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `MHQ_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(HEAP_DEPTH), "heap count above depth")
   `MHQ_ASSERT(a_pop_nonempty, clock, reset, cmd_i.pop |-> (count_ff != '0), "pop from empty heap")
   `MHQ_ASSERT(a_expired_held, clock, reset, (cmd_i.emit && (cmd_i.emit_kind == KIND_EXPIRED)) |-> pend_vld_ff, "expired beat without held entry")
   `MHQ_ASSERT(a_push_room, clock, reset, cmd_i.count_inc |-> (count_ff < CNT_W'(HEAP_DEPTH)), "insert into full heap")

endmodule

`default_nettype wire
